// File: hdl/tcie_pkg.sv
// Shared types and codes for the toy CPU instruction executor.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tcie_pkg;

  // Opcodes carried by an instruction item
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_IMM   = 4'd2;
  localparam logic [3:0] OP_STORE = 4'd3;
  localparam logic [3:0] OP_MOVE  = 4'd4;
  localparam logic [3:0] OP_ADD   = 4'd5;
  localparam logic [3:0] OP_JUMP  = 4'd11;
  localparam logic [3:0] OP_HALT  = 4'd12;

  // Result kinds
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_REPORT  = 3'd1;
  localparam logic [2:0] KIND_HALT    = 3'd2;
  localparam logic [2:0] KIND_INVALID = 3'd3;
  localparam logic [2:0] KIND_JUMP    = 3'd4;

  // Instruction classes found by the front end
  typedef enum logic [3:0] {
    CLS_LOAD,
    CLS_IMM,
    CLS_STORE,
    CLS_REPORT,
    CLS_MOVE,
    CLS_ADD,
    CLS_JUMP,
    CLS_HALT,
    CLS_INVALID
  } cls_e;

  // Classified instruction as it travels from front to back
  typedef struct packed {
    cls_e       cls;
    logic [3:0] reg_r;
    logic [7:0] operand;
    logic [7:0] log_byte;
  } instr_t;

endpackage
`default_nettype wire

// File: hdl/tcie_front.sv
// Front end: accepts instruction items, classifies them and registers them.
// Depends on tcie_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcie_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [3:0]      op_i,
  input  wire logic [3:0]      reg_r_i,
  input  wire logic [7:0]      operand_i,
  output logic                 push_valid_o,
  input  wire logic            push_ready_i,
  output tcie_pkg::instr_t     push_data_o
);
  import tcie_pkg::*;

  logic   valid_q, valid_d;
  instr_t instr_q, instr_d;
  logic   accept;

  // Stall only while the held item cannot move on
  assign in_stall_o = valid_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Classify the incoming item and form its log byte (op*10 + R, mod 256)
  always_comb begin
    instr_d.reg_r    = reg_r_i;
    instr_d.operand  = operand_i;
    instr_d.log_byte = 8'({op_i, 3'b000}) + 8'({op_i, 1'b0}) + 8'(reg_r_i);
    unique case (op_i)
      OP_LOAD:  instr_d.cls = CLS_LOAD;
      OP_IMM:   instr_d.cls = CLS_IMM;
      OP_STORE: instr_d.cls = (operand_i == 8'd0) ? CLS_REPORT : CLS_STORE;
      OP_MOVE:  instr_d.cls = CLS_MOVE;
      OP_ADD:   instr_d.cls = CLS_ADD;
      OP_JUMP:  instr_d.cls = CLS_JUMP;
      OP_HALT:  instr_d.cls = CLS_HALT;
      default:  instr_d.cls = CLS_INVALID;
    endcase
  end

  // Hold the item until the queue takes it
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= instr_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_data_o  = instr_q;

endmodule
`default_nettype wire

// File: hdl/tcie_queue.sv
// Two-entry queue of classified instructions between front and back.
// Depends on tcie_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcie_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire tcie_pkg::instr_t push_data_i,
  output logic                 head_valid_o,
  input  wire logic            pop_i,
  output tcie_pkg::instr_t     head_data_o
);
  import tcie_pkg::*;

  instr_t     entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_data_o  = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// File: hdl/tcie_back.sv
// Back end: logs each instruction into data memory and executes it against
// the register file, then drives the result register. Depends on tcie_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcie_back #(
  parameter int MEM_DEPTH = 256,
  parameter int REG_COUNT = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_valid_i,
  output logic                 pop_o,
  input  wire tcie_pkg::instr_t head_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [2:0]           kind_o,
  output logic [7:0]           value_o,
  output logic                 taken_o
);
  import tcie_pkg::*;

  localparam int AddrW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int RegW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_FIRST,
    ST_SECOND,
    ST_STORE
  } state_e;

  // Address modulo MEM_DEPTH by restoring subtraction (quotient below 16)
  function automatic logic [AddrW-1:0] addr_of(input logic [7:0] v);
    logic [12:0] r;
    r = {5'd0, v};
    for (int k = 3; k >= 0; k--) begin
      if (r >= 13'(MEM_DEPTH * (2 ** k))) begin
        r = r - 13'(MEM_DEPTH * (2 ** k));
      end
    end
    return r[AddrW-1:0];
  endfunction

  // Register number modulo REG_COUNT (quotient below 8)
  function automatic logic [RegW-1:0] reg_of(input logic [3:0] v);
    logic [6:0] r;
    r = {3'd0, v};
    for (int k = 2; k >= 0; k--) begin
      if (r >= 7'(REG_COUNT * (2 ** k))) begin
        r = r - 7'(REG_COUNT * (2 ** k));
      end
    end
    return r[RegW-1:0];
  endfunction

  // Pointer step with wrap
  function automatic logic [AddrW-1:0] inc_ptr(input logic [AddrW-1:0] p);
    return (p == AddrW'(MEM_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_e            state_q;
  instr_t            cur_q;
  logic [AddrW-1:0]  wp_q;
  logic [AddrW-1:0]  addr_q;
  logic [RegW-1:0]   dst_q;
  logic              fwd0_q, fwd1_q;
  logic              out_valid_q;
  logic [2:0]        kind_q;
  logic [7:0]        value_q;
  logic              taken_q;

  logic [7:0]        mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mem_vld_q;
  logic [7:0]        rd_q;
  logic              rd_vld_q;
  logic [7:0]        rf_q [REG_COUNT];
  logic [7:0]        ra_q, rb_q;

  logic              start, can_finish, finish, is_store;
  logic [AddrW-1:0]  wp1;
  logic [AddrW-1:0]  head_addr;
  logic [RegW-1:0]   ra_addr, rb_addr, dst_addr;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [7:0]        mem_wdata;
  logic              rf_we;
  logic [7:0]        rf_wdata;
  logic [7:0]        load_val;
  logic              jump_taken;
  logic [2:0]        res_kind;
  logic [7:0]        res_value;

  // Start an item from the queue head, finish when the result slot frees
  assign start      = (state_q == ST_FIRST) && head_valid_i;
  assign pop_o      = start;
  assign can_finish = !out_valid_q || !out_stall_i;
  assign is_store   = (cur_q.cls == CLS_STORE);
  assign finish     = ((state_q == ST_SECOND) && !is_store && can_finish)
                   || ((state_q == ST_STORE) && can_finish);
  assign wp1        = inc_ptr(wp_q);
  assign head_addr  = addr_of(head_data_i.operand);
  assign jump_taken = (ra_q == rb_q);

  // Pick register read ports and destination for the head item
  always_comb begin
    ra_addr  = reg_of(head_data_i.reg_r);
    rb_addr  = '0;
    dst_addr = reg_of(head_data_i.reg_r);
    unique case (head_data_i.cls)
      CLS_MOVE: begin
        ra_addr  = reg_of(head_data_i.operand[7:4]);
        dst_addr = reg_of(head_data_i.operand[3:0]);
      end
      CLS_ADD: begin
        ra_addr = reg_of(head_data_i.operand[7:4]);
        rb_addr = reg_of(head_data_i.operand[3:0]);
      end
      default: begin
      end
    endcase
  end

  // Loaded byte, taking the two fresh log bytes into account
  always_comb begin
    priority if (fwd1_q) begin
      load_val = cur_q.operand;
    end else if (fwd0_q) begin
      load_val = cur_q.log_byte;
    end else begin
      load_val = rd_vld_q ? rd_q : 8'd0;
    end
  end

  // Data memory write port: log byte, operand byte, then any store
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wp_q;
    mem_wdata = head_data_i.log_byte;
    unique case (state_q)
      ST_FIRST: begin
        mem_we = start;
      end
      ST_SECOND: begin
        mem_we    = is_store || can_finish;
        mem_waddr = wp1;
        mem_wdata = cur_q.operand;
      end
      ST_STORE: begin
        mem_we    = can_finish;
        mem_waddr = addr_q;
        mem_wdata = ra_q;
      end
      default: begin
      end
    endcase
  end

  // Register file write and result fields on completion
  always_comb begin
    rf_we     = 1'b0;
    rf_wdata  = ra_q;
    res_kind  = KIND_NONE;
    res_value = 8'd0;
    unique case (cur_q.cls)
      CLS_LOAD: begin
        rf_we    = 1'b1;
        rf_wdata = load_val;
      end
      CLS_IMM: begin
        rf_we    = 1'b1;
        rf_wdata = cur_q.operand;
      end
      CLS_MOVE: begin
        rf_we = 1'b1;
      end
      CLS_ADD: begin
        rf_we    = 1'b1;
        rf_wdata = ra_q + rb_q;
      end
      CLS_REPORT: begin
        res_kind  = KIND_REPORT;
        res_value = ra_q;
      end
      CLS_JUMP: begin
        res_kind  = KIND_JUMP;
        res_value = cur_q.operand;
      end
      CLS_HALT:    res_kind = KIND_HALT;
      CLS_INVALID: res_kind = KIND_INVALID;
      default: begin
      end
    endcase
    if (state_q != ST_SECOND || !finish) begin
      rf_we = 1'b0;
    end
  end

  // Sequence the item and hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FIRST;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_FIRST: begin
          if (start) begin
            state_q <= ST_SECOND;
          end
        end
        ST_SECOND: begin
          if (is_store) begin
            state_q <= ST_STORE;
            wp_q    <= inc_ptr(wp1);
          end else if (can_finish) begin
            state_q <= ST_FIRST;
            if (cur_q.cls == CLS_JUMP && jump_taken) begin
              wp_q <= addr_q;
            end else begin
              wp_q <= inc_ptr(wp1);
            end
          end
        end
        ST_STORE: begin
          if (can_finish) begin
            state_q <= ST_FIRST;
          end
        end
        default: state_q <= ST_FIRST;
      endcase
    end
  end

  // Latch item details and result payload
  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q  <= head_data_i;
      addr_q <= head_addr;
      dst_q  <= dst_addr;
      fwd0_q <= (head_addr == wp_q);
      fwd1_q <= (head_addr == wp1);
    end
    if (finish) begin
      kind_q  <= (state_q == ST_STORE) ? KIND_NONE : res_kind;
      value_q <= (state_q == ST_STORE) ? 8'd0 : res_value;
      taken_q <= (state_q == ST_SECOND) && (cur_q.cls == CLS_JUMP) && jump_taken;
    end
  end

  // Data memory: write, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (start) begin
      rd_q <= mem_q[head_addr];
    end
  end

  // Entry valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) begin
        mem_vld_q[mem_waddr] <= 1'b1;
      end
      if (start) begin
        rd_vld_q <= mem_vld_q[head_addr];
      end
    end
  end

  // Register file: two registered read ports, one write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_q[i] <= 8'd0;
      end
      ra_q <= 8'd0;
      rb_q <= 8'd0;
    end else begin
      if (rf_we) begin
        rf_q[dst_q] <= rf_wdata;
      end
      if (start) begin
        ra_q <= rf_q[ra_addr];
        rb_q <= rf_q[rb_addr];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign taken_o     = taken_q;

endmodule
`default_nettype wire

// File: hdl/toy_cpu_instruction_executor.sv
// Toy CPU instruction executor. Each accepted item is one instruction; it is
// logged as two bytes into the data memory at the program pointer and then
// executed, giving exactly one result item. A front stage classifies items
// and a two-entry queue feeds the back end, so input is taken while a result
// waits. The back end writes the log byte, the operand byte and, for a store
// to a non-zero address, the stored byte in turn through the single write
// port of the data memory. The memory needs no clearing pass after reset: a
// valid bit per entry makes unwritten entries read as zero.
`timescale 1ns / 1ps
`default_nettype none
module toy_cpu_instruction_executor #(
  parameter int MEM_DEPTH = 256,
  parameter int REG_COUNT = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [3:0] op_i,
  input  wire logic [3:0] reg_r_i,
  input  wire logic [7:0] operand_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      kind_o,
  output logic [7:0]      value_o,
  output logic            taken_o
);
  import tcie_pkg::*;

  logic   push_valid, push_ready;
  instr_t push_data;
  logic   head_valid, pop;
  instr_t head_data;

  // Accept and classify
  tcie_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .reg_r_i      (reg_r_i),
    .operand_i    (operand_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple front and back
  tcie_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_data_o  (head_data)
  );

  // Log, execute and report
  tcie_back #(
    .MEM_DEPTH (MEM_DEPTH),
    .REG_COUNT (REG_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .head_data_i  (head_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .taken_o      (taken_o)
  );

endmodule
`default_nettype wire
